[sv/spq_pkg.sv]
// spq_pkg: shared types and constants of the sorted priority queue.
// Transaction structs for the request and response channels.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned CMD_BITS    = 2;
  localparam int unsigned PORT_HANDLE = 16;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned OCC_BITS    = 6;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_LIST = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic [PORT_HANDLE-1:0]      entry_handle;
    logic signed [KEY_BITS-1:0]  entry_key;
  } req_t;

  typedef struct packed {
    logic                        ok;
    logic [PORT_HANDLE-1:0]      out_handle;
    logic signed [KEY_BITS-1:0]  out_key;
    logic [OCC_BITS-1:0]         occupancy;
    logic                        last_of_run;
  } rsp_t;

endpackage

[sv/spq_ram.sv]
// spq_ram: generic simple dual-port RAM, one write and one registered read.
// Standalone, no package dependency.
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/sorted_priority_queue_unit.sv]
// sorted_priority_queue_unit: bounded priority queue kept as a sorted list in RAM.
// Depends on spq_pkg (transaction types) and spq_ram (entry storage).
//
// Usage:
//   Request channel (req_valid/req_ready/req) carries one command per transaction:
//   enqueue, dequeue, peek front or list. Response channel (rsp_valid/rsp_ready/rsp)
//   returns one transaction per command, or one per held entry for a list, the
//   final one flagged by last_of_run. Every response reports the occupancy.
//   cfg_we/cfg_wdata write sort_mode (0 descending key, 1 ascending key); write it
//   only while no command is in flight.
// Operation:
//   Enqueue: the search stops at the insert position and the shift moves only the
//   entries behind it, so the two together walk the list once.
//   Dequeue: the front entry is read, then every entry behind it is moved down.
//   Peek: the front entry is read. List: each entry is read, then presented.
//   Full or empty refusals go straight to the response.
//   All of this runs on the single RAM read port and the one key comparator,
//   used once per cycle under the sequencer. req_ready is high only when idle.
// Reset clears occupancy and sort_mode; RAM contents are left as they are.
// A stalled receiver holds the response register; the sequencer waits for it
// before loading the next response, so nothing is lost or repeated.
`timescale 1ns / 1ps

module sorted_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KB = spq_pkg::KEY_BITS;
  localparam int unsigned RW = HANDLE_BITS + KB;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,   // front-to-back search for insert position
    S_ESH,    // shift tail entries up by one
    S_INS,    // write new entry
    S_FRD,    // read front entry
    S_FCAP,   // capture front entry
    S_DSH,    // shift entries down by one
    S_LRD,    // list: read entry
    S_LOUT,   // list: present entry
    S_EMIT    // present single response
  } state_t;

  state_t state;

  logic [CW-1:0]          count;
  logic                   mode;
  logic [CW-1:0]          scan;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          sh;
  logic                   pend;      // RAM read data in flight / valid
  logic [AW-1:0]          wr_addr;

  spq_pkg::cmd_t          cur_cmd;
  logic [HANDLE_BITS-1:0] cur_handle;
  logic signed [KB-1:0]   cur_key;

  logic                   res_ok;
  logic [HANDLE_BITS-1:0] res_handle;
  logic signed [KB-1:0]   res_key;

  // RAM ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [RW-1:0]          ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [RW-1:0]          ram_rdata;

  logic [HANDLE_BITS-1:0] rd_handle;
  logic signed [KB-1:0]   rd_key;
  logic signed [KB-1:0]   cmp_a;
  logic signed [KB-1:0]   cmp_b;
  logic                   beats;
  logic                   out_free;
  logic                   rsp_load;  // response register loads this cycle
  logic                   list_last;

  spq_ram #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_handle = ram_rdata[RW-1:KB];
  assign rd_key    = ram_rdata[KB-1:0];

  // Shared comparator: new entry beats stored entry.
  // Mode 0: new key strictly greater. Mode 1: new key strictly smaller.
  assign cmp_a = mode ? cur_key : rd_key;
  assign cmp_b = mode ? rd_key  : cur_key;
  assign beats = cmp_a < cmp_b;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign rsp_load  = out_free && (state inside {S_LOUT, S_EMIT});
  assign list_last = (scan == count - CW'(1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_SRCH: begin
        ram_re    = 1'b1;
        ram_raddr = scan[AW-1:0];
      end
      S_ESH: begin
        ram_we    = pend;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata;
        if (sh > pos) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(sh - CW'(1));
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos[AW-1:0];
        ram_wdata = {cur_handle, cur_key};
      end
      S_FRD: begin
        ram_re = 1'b1;
      end
      S_DSH: begin
        ram_we    = pend;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata;
        if (sh < count) begin
          ram_re    = 1'b1;
          ram_raddr = sh[AW-1:0];
        end
      end
      S_LRD: begin
        ram_re    = 1'b1;
        ram_raddr = scan[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      mode      <= 1'b0;
      scan      <= '0;
      pos       <= '0;
      sh        <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      // a load in the same cycle keeps valid high
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur_cmd    <= req.cmd;
            cur_handle <= HANDLE_BITS'(req.entry_handle);
            cur_key    <= req.entry_key;
            res_ok     <= 1'b1;
            res_handle <= '0;
            res_key    <= '0;
            scan       <= '0;
            pend       <= 1'b0;
            case (req.cmd)
              spq_pkg::CMD_ENQ: begin
                if (count == CW'(QUEUE_DEPTH)) begin
                  res_ok <= 1'b0;
                  state  <= S_EMIT;
                end else begin
                  state <= S_SRCH;
                end
              end
              spq_pkg::CMD_DEQ, spq_pkg::CMD_PEEK: begin
                if (count == '0) begin
                  res_ok <= 1'b0;
                  state  <= S_EMIT;
                end else begin
                  state <= S_FRD;
                end
              end
              default: begin  // list
                if (count == '0) begin
                  res_ok <= 1'b0;
                  state  <= S_EMIT;
                end else begin
                  state <= S_LRD;
                end
              end
            endcase
          end
        end

        // pend marks that ram_rdata holds entry scan-1
        S_SRCH: begin
          if (pend && beats) begin
            pos   <= scan - CW'(1);
            sh    <= count;
            pend  <= 1'b0;
            state <= S_ESH;
          end else if (scan == count) begin
            pos   <= count;
            sh    <= count;
            pend  <= 1'b0;
            state <= S_ESH;
          end else begin
            scan <= scan + CW'(1);
            pend <= 1'b1;
          end
        end

        // read sh-1, write it to sh in the next cycle
        S_ESH: begin
          if (sh > pos) begin
            wr_addr <= sh[AW-1:0];
            pend    <= 1'b1;
            sh      <= sh - CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_INS;
            end
          end
        end

        S_INS: begin
          count <= count + CW'(1);
          state <= S_EMIT;
        end

        S_FRD: begin
          state <= S_FCAP;
        end

        S_FCAP: begin
          res_handle <= rd_handle;
          res_key    <= rd_key;
          if (cur_cmd == spq_pkg::CMD_PEEK) begin
            state <= S_EMIT;
          end else begin
            sh    <= CW'(1);
            pend  <= 1'b0;
            state <= S_DSH;
          end
        end

        // read sh, write it to sh-1 in the next cycle
        S_DSH: begin
          if (sh < count) begin
            wr_addr <= AW'(sh - CW'(1));
            pend    <= 1'b1;
            sh      <= sh + CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - CW'(1);
              state <= S_EMIT;
            end
          end
        end

        S_LRD: begin
          state <= S_LOUT;
        end

        S_LOUT: begin
          if (out_free) begin
            rsp_valid       <= 1'b1;
            rsp.ok          <= 1'b1;
            rsp.out_handle  <= spq_pkg::PORT_HANDLE'(rd_handle);
            rsp.out_key     <= rd_key;
            rsp.occupancy   <= spq_pkg::OCC_BITS'(count);
            rsp.last_of_run <= list_last;
            if (list_last) begin
              state <= S_IDLE;
            end else begin
              scan  <= scan + CW'(1);
              state <= S_LRD;
            end
          end
        end

        S_EMIT: begin
          if (out_free) begin
            rsp_valid       <= 1'b1;
            rsp.ok          <= res_ok;
            rsp.out_handle  <= spq_pkg::PORT_HANDLE'(res_handle);
            rsp.out_key     <= res_key;
            rsp.occupancy   <= spq_pkg::OCC_BITS'(count);
            rsp.last_of_run <= 1'b1;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/spq_checker.sv]
// spq_checker: port-level assertions for sorted_priority_queue_unit.
// Depends on spq_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spq_pkg::rsp_t rsp
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // only a list produces non-final responses, and those always succeed
  a_run_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last_of_run |-> rsp.ok)
    else $error("non-final response without ok");

  // refusals carry no entry and end the run
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.last_of_run && rsp.out_handle == '0 && rsp.out_key == '0)
    else $error("failed response carries data");

  // one command at a time: busy right after a request transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
